/* src/hid_mouse_report_decoder_unit_defines.svh */
// assertion macros for the checker file of the mouse report decoder
// no dependencies
`ifndef HID_MOUSE_REPORT_DECODER_UNIT_DEFINES_SVH
`define HID_MOUSE_REPORT_DECODER_UNIT_DEFINES_SVH

// clocked assertion, switched off while reset is high
`define HMRD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define HMRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/hmrd_pkg.sv */
// types and constants of the mouse report decoder
// no dependencies
package hmrd_pkg;

   localparam int BTN_LIMIT  = 16;
   localparam int BITS_W     = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [2:0] {
      REG_ENABLE,
      REG_X_LAYOUT,
      REG_Y_LAYOUT,
      REG_WHEEL_LAYOUT,
      REG_BUTTON_MASK
   } reg_idx_type;

   typedef struct packed {
      logic       sign;
      logic [4:0] size_m1;
      logic [5:0] offset;
   } layout_type;

   typedef struct packed {
      logic                           enable;
      layout_type                     x_layout;
      layout_type                     y_layout;
      logic                           wheel_present;
      layout_type                     wheel_layout;
      logic [BTN_LIMIT-1:0]           btn_en;
      logic [BTN_LIMIT-1:0][5:0]      btn_pos;
   } cfg_type;

endpackage

/* src/hmrd_csr.sv */
// register bank of the mouse report decoder, with the button position table
// depends on hmrd_pkg
module hmrd_csr #(
   parameter int MAX_BUTTONS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hmrd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [hmrd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                              csr_pready,
   output logic [hmrd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output hmrd_pkg::cfg_type                 cfg,
   output logic                              cfg_wr
);
   import hmrd_pkg::*;

   logic                        enable_ff, enable_in;
   layout_type                  x_ff, x_in;
   layout_type                  y_ff, y_in;
   logic                        wpres_ff, wpres_in;
   layout_type                  wheel_ff, wheel_in;
   logic [BITS_W-1:0]           mask_ff, mask_in;
   logic [BTN_LIMIT-1:0]        btn_en_ff, btn_en_in;
   logic [BTN_LIMIT-1:0][5:0]   btn_pos_ff, btn_pos_in;

   logic [BITS_W-1:0][6:0]      rank;
   logic [BTN_LIMIT-1:0]        new_en;
   logic [BTN_LIMIT-1:0][5:0]   new_pos;
   logic                        wr;
   logic [2:0]                  idx;

   assign wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx = csr_paddr[5:3];

   // k-th set bit of the written mask is button k
   always_comb begin
      for (int p = 0; p < BITS_W; p++) begin
         rank[p] = 7'($countones(csr_pwdata & ((64'd1 << p) - 64'd1)));
      end
      new_en  = '0;
      new_pos = '0;
      for (int k = 0; k < MAX_BUTTONS; k++) begin
         for (int p = 0; p < BITS_W; p++) begin
            if (csr_pwdata[p] && (rank[p] == 7'(k))) begin
               new_en[k]  = 1'b1;
               new_pos[k] = new_pos[k] | 6'(p);
            end
         end
      end
   end

   always_comb begin
      enable_in  = enable_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      wpres_in   = wpres_ff;
      wheel_in   = wheel_ff;
      mask_in    = mask_ff;
      btn_en_in  = btn_en_ff;
      btn_pos_in = btn_pos_ff;
      cfg_wr     = 1'b0;
      if (wr) begin
         case (reg_idx_type'(idx))
            REG_ENABLE: begin
               enable_in = csr_pwdata[0];
               cfg_wr    = 1'b1;
            end
            REG_X_LAYOUT: begin
               x_in   = layout_type'(csr_pwdata[11:0]);
               cfg_wr = 1'b1;
            end
            REG_Y_LAYOUT: begin
               y_in   = layout_type'(csr_pwdata[11:0]);
               cfg_wr = 1'b1;
            end
            REG_WHEEL_LAYOUT: begin
               wheel_in = layout_type'(csr_pwdata[11:0]);
               wpres_in = csr_pwdata[12];
               cfg_wr   = 1'b1;
            end
            REG_BUTTON_MASK: begin
               mask_in    = csr_pwdata;
               btn_en_in  = new_en;
               btn_pos_in = new_pos;
               cfg_wr     = 1'b1;
            end
            default: cfg_wr = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         x_ff       <= '0;
         y_ff       <= '0;
         wpres_ff   <= 1'b0;
         wheel_ff   <= '0;
         mask_ff    <= '0;
         btn_en_ff  <= '0;
         btn_pos_ff <= '0;
      end else begin
         enable_ff  <= enable_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         wpres_ff   <= wpres_in;
         wheel_ff   <= wheel_in;
         mask_ff    <= mask_in;
         btn_en_ff  <= btn_en_in;
         btn_pos_ff <= btn_pos_in;
      end
   end

   always_comb begin
      case (reg_idx_type'(idx))
         REG_ENABLE:       csr_prdata = {63'd0, enable_ff};
         REG_X_LAYOUT:     csr_prdata = {52'd0, x_ff};
         REG_Y_LAYOUT:     csr_prdata = {52'd0, y_ff};
         REG_WHEEL_LAYOUT: csr_prdata = {51'd0, wpres_ff, wheel_ff};
         REG_BUTTON_MASK:  csr_prdata = mask_ff;
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.enable        = enable_ff;
      cfg.x_layout      = x_ff;
      cfg.y_layout      = y_ff;
      cfg.wheel_present = wpres_ff;
      cfg.wheel_layout  = wheel_ff;
      cfg.btn_en        = btn_en_ff;
      cfg.btn_pos       = btn_pos_ff;
   end

endmodule

/* src/hmrd_field.sv */
// extracts one report field at a configured offset and size, with sign extension
// depends on hmrd_pkg
module hmrd_field (
   input  logic [hmrd_pkg::BITS_W-1:0] bits,
   input  hmrd_pkg::layout_type        layout,
   output logic [31:0]                 value
);
   import hmrd_pkg::*;

   logic [BITS_W-1:0] shifted;
   logic [31:0]       mask;
   logic [31:0]       raw;

   always_comb begin
      shifted = bits >> layout.offset;
      mask    = 32'hFFFF_FFFF >> (5'd31 - layout.size_m1);
      raw     = shifted[31:0] & mask;
      // top bit of the field fills the rest when signed
      if (layout.sign && raw[layout.size_m1]) begin
         value = raw | ~mask;
      end else begin
         value = raw;
      end
   end

endmodule

/* src/hid_mouse_report_decoder_unit.sv */
// pipeline: an accepted report is registered in the report stage, its event in the event register
// throughput: one report per cycle while no event is stalled; req_stall follows rsp_stall in the
// same cycle only when the report stage holds a report with an event behind a stalled event
// reset: synchronous, clears both valids, the configuration registers and the button map
// depends on hmrd_pkg, hmrd_csr and hmrd_field
module hid_mouse_report_decoder_unit #(
   parameter int REPORT_BYTES = 8,
   parameter int MAX_BUTTONS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [63:0]                       req_report_data,
   input  logic [3:0]                        req_report_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_delta_x,
   output logic signed [31:0]                rsp_delta_y,
   output logic signed [15:0]                rsp_wheel_delta,
   output logic [15:0]                       rsp_button_map,
   output logic                              rsp_relative_flag,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hmrd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [hmrd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [hmrd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import hmrd_pkg::*;

   localparam int DATA_W = 8 * REPORT_BYTES;

   cfg_type                 cfg;
   logic                    cfg_wr;

   logic                    req_take;
   logic [DATA_W-1:0]       masked;
   logic                    s1_valid_ff, s1_valid_in;
   logic [DATA_W-1:0]       s1_data_ff, s1_data_in;
   logic [BITS_W-1:0]       bits;

   logic [31:0]             dx, dy, wh_raw, wh;
   logic [MAX_BUTTONS-1:0]  map_raw;
   logic [15:0]             map16;
   logic [MAX_BUTTONS-1:0]  prev_ff, prev_in;
   logic                    changed, emit, out_free, s1_move;

   logic                    out_valid_ff, out_valid_in;
   logic [31:0]             dx_ff, dy_ff;
   logic [15:0]             wh_ff, map_ff;
   logic                    rel_ff;

   assign csr_pready = 1'b1;

   hmrd_csr #(
      .MAX_BUTTONS (MAX_BUTTONS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg),
      .cfg_wr      (cfg_wr)
   );

   // bytes at or past the length read as zero
   always_comb begin
      for (int i = 0; i < REPORT_BYTES; i++) begin
         masked[8*i +: 8] = (req_report_length > 4'(i)) ? req_report_data[8*i +: 8] : 8'h00;
      end
   end

   assign req_take = req_valid && !req_stall;

   always_comb begin
      bits = '0;
      bits[DATA_W-1:0] = s1_data_ff;
   end

   hmrd_field u_x (.bits(bits), .layout(cfg.x_layout),     .value(dx));
   hmrd_field u_y (.bits(bits), .layout(cfg.y_layout),     .value(dy));
   hmrd_field u_w (.bits(bits), .layout(cfg.wheel_layout), .value(wh_raw));

   assign wh = cfg.wheel_present ? wh_raw : 32'd0;

   always_comb begin
      for (int k = 0; k < MAX_BUTTONS; k++) begin
         map_raw[k] = cfg.btn_en[k] && bits[cfg.btn_pos[k]];
      end
      map16 = '0;
      map16[MAX_BUTTONS-1:0] = map_raw;
   end

   assign changed  = (map_raw != prev_ff);
   assign emit     = cfg.enable && ((dx != 32'd0) || (dy != 32'd0) || (wh != 32'd0) || changed);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_move  = s1_valid_ff && (!emit || out_free);
   assign req_stall = s1_valid_ff && !s1_move;

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !s1_move);
      s1_data_in  = req_take ? masked : s1_data_ff;

      if (s1_move && emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      // map of every decoded report is kept, event or not
      if (cfg_wr) begin
         prev_in = '0;
      end else if (s1_move && cfg.enable) begin
         prev_in = map_raw;
      end else begin
         prev_in = prev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      if (s1_move && emit) begin
         dx_ff  <= dx;
         dy_ff  <= dy;
         wh_ff  <= wh[15:0];
         map_ff <= map16;
         rel_ff <= cfg.x_layout.sign;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_delta_x       = dx_ff;
   assign rsp_delta_y       = dy_ff;
   assign rsp_wheel_delta   = wh_ff;
   assign rsp_button_map    = map_ff;
   assign rsp_relative_flag = rel_ff;

endmodule

/* src/hmrd_checker.sv */
// port-level checks of the mouse report decoder, bound to the top level
// depends on hid_mouse_report_decoder_unit_defines.svh
`include "hid_mouse_report_decoder_unit_defines.svh"

module hmrd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_delta_x,
   input logic signed [31:0] rsp_delta_y,
   input logic signed [15:0] rsp_wheel_delta,
   input logic [15:0]        rsp_button_map
);

   `HMRD_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "event valid after reset")

   // input side only backs up behind a stalled event
   `HMRD_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input stalled without a stalled event")

   // an event from an empty output stage comes from an accepted transaction that passed the report stage
   `HMRD_ASSERT(a_latency, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2), "event without matching transaction")

   `HMRD_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_delta_x) && $stable(rsp_delta_y) && $stable(rsp_wheel_delta) && $stable(rsp_button_map)), "stalled event changed")

endmodule

bind hid_mouse_report_decoder_unit hmrd_checker u_hmrd_checker (.*);

/* bench/hid_mouse_report_decoder_unit_test.sv */
// self-checking bench for the mouse report decoder: directed table, then random reports
// and register settings, every event compared against given values or a local decoder model
// depends on hmrd_pkg and hid_mouse_report_decoder_unit
module hid_mouse_report_decoder_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hmrd_pkg::*;

   localparam int RANDOM_REPORTS = 1450;
   localparam int CALM_TAIL      = 150;

   typedef struct packed {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [15:0] wheel;
      logic [15:0]        buttons;
      logic               rel;
   } mouse_event_type;

   typedef enum int {ROW_WRITE, ROW_REPORT} row_kind_type;
   typedef enum int {CHECK_MODEL, CHECK_NONE, CHECK_GIVEN} row_check_type;

   typedef struct {
      row_kind_type    kind;
      logic [2:0]      reg_idx;
      logic [63:0]     value;
      logic [3:0]      len;
      row_check_type   check;
      mouse_event_type given;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_report_data;
   logic [3:0]  req_report_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic signed [31:0] rsp_delta_x;
   logic signed [31:0] rsp_delta_y;
   logic signed [15:0] rsp_wheel_delta;
   logic [15:0] rsp_button_map;
   logic        rsp_relative_flag;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   // decoder model state
   logic        cfg_enable;
   logic [11:0] cfg_x;
   logic [11:0] cfg_y;
   logic [12:0] cfg_wheel;
   logic [63:0] cfg_buttons;
   logic [15:0] prev_buttons;

   mouse_event_type expected_events[$];
   stim_row_type    stim_table[$];

   int  failures;
   int  reports_sent;
   int  events_checked;
   int  register_writes;
   int  gap_rate;
   bit  calm;

   hid_mouse_report_decoder_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("** hid_mouse_report_decoder_unit: FAILED **");
      $finish;
   end

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) note_failure($sformatf("%s expected %h got %h", name, want, got));
   endtask

   function automatic logic [31:0] pick_field(input logic [63:0] bits, input layout_type lay);
      logic [5:0]  sz;
      logic [31:0] mask;
      logic [31:0] v;
      sz = {1'b0, lay.size_m1} + 6'd1;
      mask = (sz == 6'd32) ? '1 : ((32'd1 << sz) - 32'd1);
      v = 32'(bits >> lay.offset) & mask;
      if (lay.sign && sz < 6'd32 && v[sz - 6'd1]) v |= ~mask;
      return v;
   endfunction

   function automatic void decode_report(input logic [63:0] data, input logic [3:0] len,
                                         output logic fired, output mouse_event_type ev);
      logic [63:0] bits;
      int          n;
      int          k;
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] wh;
      logic [15:0] map;
      logic        changed;
      fired = 1'b0;
      ev = '0;
      if (!cfg_enable) return;
      n = (len > 4'd8) ? 8 : int'(len);
      bits = data;
      if (n < 8) bits &= (64'd1 << (8 * n)) - 64'd1;
      dx = pick_field(bits, cfg_x);
      dy = pick_field(bits, cfg_y);
      wh = cfg_wheel[12] ? pick_field(bits, cfg_wheel[11:0]) : 32'd0;
      map = '0;
      k = 0;
      for (int p = 0; p < 64; p++) begin
         if (cfg_buttons[p] && k < BTN_LIMIT) begin
            map[k] = bits[p];
            k++;
         end
      end
      // the map is kept even when nothing is emitted
      changed = (map != prev_buttons);
      prev_buttons = map;
      // wheel test uses the full value, so an event may carry a zero wheel field
      fired = (dx != 0) || (dy != 0) || (wh != 0) || changed;
      ev.dx = dx;
      ev.dy = dy;
      ev.wheel = wh[15:0];
      ev.buttons = map;
      ev.rel = cfg_x[11];
   endfunction

   function automatic void store_setting(input logic [2:0] idx, input logic [63:0] value);
      case (idx)
         REG_ENABLE:       cfg_enable = value[0];
         REG_X_LAYOUT:     cfg_x = value[11:0];
         REG_Y_LAYOUT:     cfg_y = value[11:0];
         REG_WHEEL_LAYOUT: cfg_wheel = value[12:0];
         REG_BUTTON_MASK:  cfg_buttons = value;
         default:          return;
      endcase
      prev_buttons = '0;
   endfunction

   function automatic logic [63:0] setting_value(input logic [2:0] idx);
      case (idx)
         REG_ENABLE:       return {63'd0, cfg_enable};
         REG_X_LAYOUT:     return {52'd0, cfg_x};
         REG_Y_LAYOUT:     return {52'd0, cfg_y};
         REG_WHEEL_LAYOUT: return {51'd0, cfg_wheel};
         default:          return cfg_buttons;
      endcase
   endfunction

   function automatic logic [11:0] random_layout();
      layout_type lay;
      case ($urandom_range(0, 3))
         0:       lay.offset = 6'd0;
         1:       lay.offset = 6'd63;
         default: lay.offset = 6'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 4))
         0:       lay.size_m1 = 5'd0;
         1:       lay.size_m1 = 5'd31;
         2:       lay.size_m1 = 5'd7;
         default: lay.size_m1 = 5'($urandom_range(0, 31));
      endcase
      lay.sign = 1'($urandom_range(0, 1));
      return lay;
   endfunction

   function automatic logic [63:0] random_bits();
      return {$urandom, $urandom};
   endfunction

   function automatic stim_row_type wr(input logic [2:0] idx, input logic [63:0] value);
      stim_row_type r;
      r.kind = ROW_WRITE;
      r.reg_idx = idx;
      r.value = value;
      r.len = '0;
      r.check = CHECK_NONE;
      r.given = '0;
      return r;
   endfunction

   function automatic stim_row_type rpt(input logic [63:0] data, input logic [3:0] len,
                                        input row_check_type chk, input logic [31:0] dx,
                                        input logic [31:0] dy, input logic [15:0] wh,
                                        input logic [15:0] map, input logic rel);
      stim_row_type r;
      r.kind = ROW_REPORT;
      r.reg_idx = '0;
      r.value = data;
      r.len = len;
      r.check = chk;
      r.given = '{dx: dx, dy: dy, wheel: wh, buttons: map, rel: rel};
      return r;
   endfunction

   task automatic csr_cycle(input logic wr_en, input logic [2:0] idx,
                            input logic [63:0] data, output logic [63:0] rd);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr_en;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // block must be idle: every event in, and trailing silent reports through the pipe
   task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
      logic [63:0] rd;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_cycle(1'b1, idx, value, rd);
      store_setting(idx, value);
      register_writes++;
      if (idx <= REG_BUTTON_MASK) begin
         csr_cycle(1'b0, idx, 64'd0, rd);
         check_field($sformatf("register %0d readback", idx), setting_value(idx), rd);
      end
   endtask

   task automatic send_report(input logic [63:0] data, input logic [3:0] len,
                              output logic fired, output mouse_event_type ev);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < gap_rate) gap = $urandom_range(1, 17);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_report_data <= data;
      req_report_length <= len;
      do @(posedge clock); while (req_stall !== 1'b0);
      reports_sent++;
      decode_report(data, len, fired, ev);
   endtask

   // receiver side: stall bursts at a rate that is redrawn for each window
   initial begin
      int stall_left;
      int stall_rate;
      int window;
      stall_left = 0;
      stall_rate = 0;
      window = 0;
      forever begin
         @(negedge clock);
         if (window == 0) begin
            window = 200;
            case ($urandom_range(0, 2))
               0:       stall_rate = 0;
               1:       stall_rate = 8;
               default: stall_rate = 30;
            endcase
         end
         window--;
         if (calm || reset) begin
            rsp_stall <= 1'b0;
            stall_left = 0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if ($urandom_range(0, 99) < stall_rate) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(1, 17) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // event checker
   initial begin
      mouse_event_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_events.size() == 0) begin
               note_failure($sformatf("unexpected event dx %h dy %h wheel %h buttons %h",
                                      rsp_delta_x, rsp_delta_y, rsp_wheel_delta,
                                      rsp_button_map));
            end else begin
               want = expected_events.pop_front();
               check_field("delta_x", want.dx, rsp_delta_x);
               check_field("delta_y", want.dy, rsp_delta_y);
               check_field("wheel_delta", want.wheel, rsp_wheel_delta);
               check_field("button_map", want.buttons, rsp_button_map);
               check_field("relative_flag", want.rel, rsp_relative_flag);
               events_checked++;
            end
         end
      end
   end

   initial begin
      stim_row_type    row;
      logic            fired;
      mouse_event_type ev;
      logic [63:0]     data;
      logic [63:0]     last_data;
      logic [63:0]     value;
      logic [3:0]      len;
      int              items;
      int              decoded;

      reset = 1'b1;
      req_valid = 1'b0;
      req_report_data = '0;
      req_report_length = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      failures = 0;
      reports_sent = 0;
      events_checked = 0;
      register_writes = 0;
      gap_rate = 15;
      calm = 1'b0;
      cfg_enable = 1'b0;
      cfg_x = '0;
      cfg_y = '0;
      cfg_wheel = '0;
      cfg_buttons = '0;
      prev_buttons = '0;
      last_data = '0;

      // disabled after reset, then zero layouts
      stim_table.push_back(rpt('1, 4'd8, CHECK_NONE, 0, 0, 0, 0, 0));
      stim_table.push_back(wr(REG_ENABLE, 64'd1));
      stim_table.push_back(rpt(64'd0, 4'd0, CHECK_NONE, 0, 0, 0, 0, 0));
      // signed bytes: x byte 0, y byte 1, wheel byte 2, buttons byte 3
      stim_table.push_back(wr(REG_X_LAYOUT, 64'h9C0));
      stim_table.push_back(wr(REG_Y_LAYOUT, 64'h9C8));
      stim_table.push_back(wr(REG_WHEEL_LAYOUT, 64'h19D0));
      stim_table.push_back(wr(REG_BUTTON_MASK, 64'hFF00_0000));
      stim_table.push_back(rpt(64'hFF01, 4'd8, CHECK_GIVEN, 1, '1, 0, 0, 1));
      stim_table.push_back(rpt(64'hFF01, 4'd1, CHECK_GIVEN, 1, 0, 0, 0, 1));
      stim_table.push_back(rpt('1, 4'd0, CHECK_NONE, 0, 0, 0, 0, 0));
      stim_table.push_back(rpt(64'h0380_0000, 4'd4, CHECK_GIVEN, 0, 0, 16'hFF80, 3, 1));
      stim_table.push_back(rpt(64'h0380_0000, 4'd4, CHECK_MODEL, 0, 0, 0, 0, 0));
      stim_table.push_back(rpt(64'd0, 4'd8, CHECK_GIVEN, 0, 0, 0, 0, 1));
      stim_table.push_back(rpt(64'd0, 4'd8, CHECK_NONE, 0, 0, 0, 0, 0));
      // oversized lengths clamp to the full report
      stim_table.push_back(rpt(64'h7F, 4'd15, CHECK_MODEL, 0, 0, 0, 0, 0));
      stim_table.push_back(rpt(64'hFF00_0000_0000_0080, 4'd9, CHECK_MODEL, 0, 0, 0, 0, 0));
      // full-width unsigned x at bit 32
      stim_table.push_back(wr(REG_X_LAYOUT, 64'h7E0));
      stim_table.push_back(rpt(64'hFFFF_FFFF_0000_0000, 4'd8, CHECK_GIVEN, '1, 0, 0, 0, 0));
      // x at bit 63: everything past the report reads as zero
      stim_table.push_back(wr(REG_X_LAYOUT, 64'hFFF));
      stim_table.push_back(rpt(64'h8000_0000_0000_0000, 4'd8, CHECK_GIVEN, 1, 0, 0, 0, 1));
      stim_table.push_back(rpt(64'h8000_0000_0000_0000, 4'd7, CHECK_NONE, 0, 0, 0, 0, 0));
      // 32-bit wheel whose low half is zero still fires
      stim_table.push_back(wr(REG_X_LAYOUT, 64'h9E8));
      stim_table.push_back(wr(REG_Y_LAYOUT, 64'h9F0));
      stim_table.push_back(wr(REG_WHEEL_LAYOUT, 64'h1FC0));
      stim_table.push_back(rpt(64'h0001_0000, 4'd8, CHECK_GIVEN, 0, 0, 0, 0, 1));
      // more mask bits than buttons
      stim_table.push_back(wr(REG_BUTTON_MASK, '1));
      stim_table.push_back(rpt(64'hFFFF_0000_0000_A5C3, 4'd8, CHECK_MODEL, 0, 0, 0, 0, 0));
      stim_table.push_back(rpt('1, 4'd8, CHECK_MODEL, 0, 0, 0, 0, 0));
      stim_table.push_back(wr(REG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE));
      stim_table.push_back(rpt('1, 4'd8, CHECK_NONE, 0, 0, 0, 0, 0));
      stim_table.push_back(wr(REG_ENABLE, 64'd1));
      stim_table.push_back(wr(REG_WHEEL_LAYOUT, 64'd0));
      stim_table.push_back(rpt(64'h5, 4'd8, CHECK_MODEL, 0, 0, 0, 0, 0));
      // write to an unmapped register must leave the button history alone
      stim_table.push_back(wr(3'd5, '1));
      stim_table.push_back(rpt(64'h5, 4'd8, CHECK_MODEL, 0, 0, 0, 0, 0));
      stim_table.push_back(rpt(64'h0, 4'd8, CHECK_MODEL, 0, 0, 0, 0, 0));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (row.kind == ROW_WRITE) begin
            write_register(row.reg_idx, row.value);
         end else begin
            send_report(row.value, row.len, fired, ev);
            if (row.check == CHECK_GIVEN) expected_events.push_back(row.given);
            else if (row.check == CHECK_MODEL && fired) expected_events.push_back(ev);
         end
      end

      decoded = 0;
      while (decoded < RANDOM_REPORTS) begin
         // no register traffic in the closing stretch, so reports run back to back
         if (!calm) begin
            for (int r = 0; r < 5; r++) begin
               if ($urandom_range(0, 9) < 6) begin
                  value = random_bits();
                  case (r)
                     0:       value[0] = ($urandom_range(0, 9) != 0);
                     1, 2:    value[11:0] = random_layout();
                     3:       value[11:0] = random_layout();
                     default: begin
                        case ($urandom_range(0, 4))
                           0:       value = '0;
                           1:       value = '1;
                           2:       value = value & random_bits() & random_bits();
                           default: ;
                        endcase
                     end
                  endcase
                  write_register(3'(r), value);
               end
            end
            if ($urandom_range(0, 9) == 0) write_register(3'($urandom_range(5, 7)), random_bits());
         end
         case ($urandom_range(0, 2))
            0:       gap_rate = 0;
            1:       gap_rate = 10;
            default: gap_rate = 35;
         endcase
         items = cfg_enable ? $urandom_range(20, 80) : $urandom_range(3, 8);
         repeat (items) begin
            case ($urandom_range(0, 9))
               0:       data = '0;
               1:       data = '1;
               2, 3:    data = last_data;
               4:       data = random_bits() & random_bits() & random_bits();
               default: data = random_bits();
            endcase
            len = ($urandom_range(0, 9) < 7) ? 4'd8 : 4'($urandom_range(0, 15));
            last_data = data;
            if (cfg_enable) decoded++;
            if (decoded >= RANDOM_REPORTS - CALM_TAIL) calm = 1'b1;
            send_report(data, len, fired, ev);
            if (fired) expected_events.push_back(ev);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("%0d reports sent over %0d register writes, %0d events compared",
               reports_sent, register_writes, events_checked);
      $display("%0d mismatches seen", failures);
      if (failures == 0) begin
         $display("** hid_mouse_report_decoder_unit: PASSED **");
      end else begin
         $display("** hid_mouse_report_decoder_unit: FAILED **");
      end
      $finish;
   end

endmodule
